@@ rtl/core/dotted_ipv4_address_parser_assert.svh @@
// Assertion macros for the dotted IPv4 address parser.
// Uses clk and arst_n from the including module; empty under SYNTHESIS.
`ifndef DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`define DOTTED_IPV4_ADDRESS_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define DIP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dipv4 assertion failed");
`define DIP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dipv4 assertion failed");
`else
`define DIP_ASSERT_SAME(label, ante, cons)
`define DIP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/dipv4_pkg.sv @@
// Types and character constants for the dotted IPv4 address parser.
// No dependencies.
`default_nettype none
package dipv4_pkg;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_ZERO   = 4'b0010,
		PH_PREFIX = 4'b0100,
		PH_DIGITS = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_CHAR  = 3'd1,
		ERR_DOTS  = 3'd2,
		ERR_RANGE = 3'd3,
		ERR_EMPTY = 3'd4
	} err_t;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [3:0] HEX_LETTER_OFS = 4'd9;
	localparam logic [3:0] OCT_MAX  = 4'd7;

endpackage
`default_nettype wire

@@ rtl/core/dipv4_char_if.sv @@
// Character channel: valid/ready handshake carrying one string character per beat.
// No dependencies.
`default_nettype none
interface dipv4_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dipv4_result_if.sv @@
// Result channel: valid/ready handshake carrying one parsed address per beat.
// No dependencies.
`default_nettype none
interface dipv4_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic [2:0]  error_code;

	modport source (output valid, output address, output error_code, input ready);
	modport sink (input valid, input address, input error_code, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dotted_ipv4_address_parser.sv @@
// Streaming dotted IPv4 address parser (a, a.b, a.b.c, a.b.c.d; dec/oct/hex parts).
// Depends on dipv4_pkg, dipv4_char_if, dipv4_result_if and the assertion header.
//
//   channel   dir   beat contents
//   chars     in    ch[7:0], last
//   results   out   address[31:0], error_code[2:0]
//
// Stages: input register, one step of digit/dot logic, result register.
// One character per cycle unless a stalled result holds back a last character.
// As a character leaves the input register, parse state and any result are registered.
// Reset clears the parse state and both valid flags.
// A stalled result only holds back a character flagged last; others keep flowing.
`default_nettype none
`include "dotted_ipv4_address_parser_assert.svh"
module dotted_ipv4_address_parser (
	input  wire            clk,
	input  wire            arst_n,
	dipv4_char_if.sink     chars,
	dipv4_result_if.source results
);
	import dipv4_pkg::*;

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	logic        adv;

	logic [31:0]      part_value_q;
	logic             part_ovf_q;
	base_t            base_q;
	phase_t           phase_q;
	logic [1:0]       dot_count_q;
	logic [2:0][7:0]  lead_q;
	err_t             err_q;

	logic [31:0]      n_value;
	logic             n_ovf;
	base_t            n_base;
	phase_t           n_phase;
	logic [1:0]       n_dot;
	logic [2:0][7:0]  n_lead;
	err_t             n_err;

	logic        out_valid_q;
	logic [31:0] out_address_q;
	err_t        out_err_q;

	logic [31:0] res_address;
	err_t        res_err;

	base_t       eff_base;
	logic        is_dec;
	logic        is_hex_letter;
	logic        dig_ok;
	logic [3:0]  dig_val;
	logic [35:0] prod;
	logic [35:0] sum;

	assign adv = valid_s1 && (!last_s1 || !out_valid_q || results.ready);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	// digit decode and accumulate
	always_comb begin
		eff_base = (phase_q == PH_START) ? BASE_DEC : base_q;
		is_dec = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
		is_hex_letter = ((ch_s1 >= CH_LO_A) && (ch_s1 <= CH_LO_F)) ||
			((ch_s1 >= CH_UP_A) && (ch_s1 <= CH_UP_F));
		dig_val = is_dec ? ch_s1[3:0] : ch_s1[3:0] + HEX_LETTER_OFS;
		case (eff_base)
			BASE_HEX: dig_ok = is_dec || is_hex_letter;
			BASE_OCT: dig_ok = is_dec && (ch_s1[3:0] <= OCT_MAX);
			default:  dig_ok = is_dec;
		endcase
		case (eff_base)
			BASE_HEX: prod = {part_value_q, 4'b0000};
			BASE_OCT: prod = {1'b0, part_value_q, 3'b000};
			default:  prod = {1'b0, part_value_q, 3'b000} + {3'b000, part_value_q, 1'b0};
		endcase
		sum = prod + {32'd0, dig_val};
	end

	// next parse state and result
	always_comb begin
		n_value = part_value_q;
		n_ovf   = part_ovf_q;
		n_base  = base_q;
		n_phase = phase_q;
		n_dot   = dot_count_q;
		n_lead  = lead_q;
		n_err   = err_q;
		res_err = err_q;
		res_address = 32'd0;

		if (err_q == ERR_NONE) begin
			if (ch_s1 == CH_DOT) begin
				if (phase_q == PH_START) begin
					n_err = ERR_EMPTY;
				end else if (dot_count_q == 2'd3) begin
					n_err = ERR_DOTS;
				end else if (part_ovf_q || (part_value_q[31:8] != 24'd0)) begin
					n_err = ERR_RANGE;
				end else begin
					case (dot_count_q)
						2'd0:    n_lead[0] = part_value_q[7:0];
						2'd1:    n_lead[1] = part_value_q[7:0];
						default: n_lead[2] = part_value_q[7:0];
					endcase
					n_dot   = dot_count_q + 2'd1;
					n_value = 32'd0;
					n_ovf   = 1'b0;
					n_base  = BASE_DEC;
					n_phase = PH_START;
				end
			end else if ((phase_q == PH_START) && (ch_s1 == CH_ZERO)) begin
				n_phase = PH_ZERO;
				n_base  = BASE_OCT;
				n_value = 32'd0;
			end else if ((phase_q == PH_ZERO) && ((ch_s1 == CH_LO_X) || (ch_s1 == CH_UP_X))) begin
				n_phase = PH_PREFIX;
				n_base  = BASE_HEX;
			end else if (!dig_ok) begin
				n_err  = ERR_CHAR;
				n_base = eff_base;
			end else begin
				n_base  = eff_base;
				n_value = sum[31:0];
				n_ovf   = part_ovf_q || (sum[35:32] != 4'd0);
				n_phase = PH_DIGITS;
			end
		end

		if (last_s1) begin
			res_err = n_err;
			if (n_err == ERR_NONE) begin
				if (n_phase == PH_START) begin
					res_err = ERR_EMPTY;
				end else begin
					case (n_dot)
						2'd0: if (n_ovf) res_err = ERR_RANGE;
						2'd1: if (n_ovf || (n_value[31:24] != 8'd0)) res_err = ERR_RANGE;
						2'd2: if (n_ovf || (n_value[31:16] != 16'd0)) res_err = ERR_RANGE;
						default: if (n_ovf || (n_value[31:8] != 24'd0)) res_err = ERR_RANGE;
					endcase
				end
			end
			if (res_err == ERR_NONE) begin
				res_address[7:0]   = (n_dot > 2'd0) ? n_lead[0] : n_value[31:24];
				res_address[15:8]  = (n_dot > 2'd1) ? n_lead[1] : n_value[23:16];
				res_address[23:16] = (n_dot > 2'd2) ? n_lead[2] : n_value[15:8];
				res_address[31:24] = n_value[7:0];
			end
			n_value = 32'd0;
			n_ovf   = 1'b0;
			n_base  = BASE_DEC;
			n_phase = PH_START;
			n_dot   = 2'd0;
			n_lead  = '0;
			n_err   = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_value_q <= 32'd0;
			part_ovf_q   <= 1'b0;
			base_q       <= BASE_DEC;
			phase_q      <= PH_START;
			dot_count_q  <= 2'd0;
			lead_q       <= '0;
			err_q        <= ERR_NONE;
		end else if (adv) begin
			part_value_q <= n_value;
			part_ovf_q   <= n_ovf;
			base_q       <= n_base;
			phase_q      <= n_phase;
			dot_count_q  <= n_dot;
			lead_q       <= n_lead;
			err_q        <= n_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_address_q <= res_address;
			out_err_q     <= res_err;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.address    = out_address_q;
	assign results.error_code = out_err_q;

	`DIP_ASSERT_SAME(a_err_zero_addr, out_valid_q && (out_err_q != ERR_NONE), out_address_q == 32'd0)
	`DIP_ASSERT_NEXT(a_last_gives_result, adv && last_s1, out_valid_q)
	`DIP_ASSERT_NEXT(a_last_clears_state, adv && last_s1,
		(dot_count_q == 2'd0) && (err_q == ERR_NONE) && (phase_q == PH_START))
	`DIP_ASSERT_NEXT(a_error_sticks, adv && !last_s1 && (err_q != ERR_NONE), $stable(err_q))
	`DIP_ASSERT_SAME(a_no_drop, out_valid_q && !results.ready && valid_s1 && last_s1, !adv)

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for dotted_ipv4_address_parser: streams address strings
// through the character channel and checks every parsed result against a local model.
// Depends on dipv4_pkg, dipv4_char_if, dipv4_result_if and the parser RTL.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import dipv4_pkg::*;

	localparam int          CYCLE_LIMIT = 200000;
	localparam logic [7:0]  CH_NUL      = 8'h00;
	localparam logic [7:0]  CH_TAB      = 8'h09;
	localparam logic [7:0]  CH_SPACE    = 8'h20;

	typedef logic [7:0] char_seq_t[$];

	typedef struct {
		logic [31:0] address;
		err_t        code;
	} addr_result_t;

	logic clk;
	logic arst_n;

	dipv4_char_if   chars_bus();
	dipv4_result_if results_bus();

	dotted_ipv4_address_parser i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.results (results_bus)
	);

	// parse state of the string in flight
	base_t       cur_base;
	phase_t      cur_phase;
	logic [31:0] cur_value;
	logic        cur_ovf;
	int          dots_seen;
	logic [23:0] octets_done;
	err_t        first_err;

	addr_result_t pending_addresses[$];
	addr_result_t want;
	int           error_count = 0;
	int           cycle_count = 0;
	int           sent_chars = 0;
	int           sink_hold = 0;
	bit           sink_quiet = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_part();
		cur_value = '0;
		cur_ovf   = 1'b0;
		cur_base  = BASE_DEC;
		cur_phase = PH_START;
	endfunction

	function automatic void clear_string();
		clear_part();
		dots_seen   = 0;
		octets_done = '0;
		first_err   = ERR_NONE;
	endfunction

	function automatic int digit_value(logic [7:0] c, base_t b);
		int d;
		d = -1;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = int'(c - CH_ZERO);
		end else if (b == BASE_HEX && c >= CH_LO_A && c <= CH_LO_F) begin
			d = int'(c - CH_LO_A) + 10;
		end else if (b == BASE_HEX && c >= CH_UP_A && c <= CH_UP_F) begin
			d = int'(c - CH_UP_A) + 10;
		end
		if (b == BASE_OCT && d > int'(OCT_MAX)) begin
			d = -1;
		end
		return d;
	endfunction

	function automatic void take_char(logic [7:0] c);
		int          d;
		logic [39:0] radix;
		logic [39:0] next;
		if (c == CH_DOT) begin
			if (cur_phase == PH_START) begin
				first_err = ERR_EMPTY;
			end else if (dots_seen >= 3) begin
				first_err = ERR_DOTS;
			end else if (cur_ovf || cur_value > 32'hFF) begin
				first_err = ERR_RANGE;
			end else begin
				octets_done[8*dots_seen +: 8] = cur_value[7:0];
				dots_seen++;
				clear_part();
			end
			return;
		end
		if (cur_phase == PH_START) begin
			if (c == CH_ZERO) begin
				cur_phase = PH_ZERO;
				cur_base  = BASE_OCT;
				cur_value = '0;
				return;
			end
			cur_base = BASE_DEC;
		end else if (cur_phase == PH_ZERO && (c == CH_LO_X || c == CH_UP_X)) begin
			cur_base  = BASE_HEX;
			cur_phase = PH_PREFIX;
			return;
		end
		d = digit_value(c, cur_base);
		if (d < 0) begin
			first_err = ERR_CHAR;
			return;
		end
		radix = (cur_base == BASE_HEX) ? 40'd16 : (cur_base == BASE_OCT) ? 40'd8 : 40'd10;
		next  = {8'h00, cur_value} * radix + 40'(d);
		if (next[39:32] != '0) begin
			cur_ovf = 1'b1;
		end
		cur_value = next[31:0];
		cur_phase = PH_DIGITS;
	endfunction

	function automatic void track_char(logic [7:0] c, logic fin);
		addr_result_t r;
		int           width;
		int           k;
		if (first_err == ERR_NONE) begin
			take_char(c);
		end
		if (!fin) begin
			return;
		end
		if (first_err == ERR_NONE) begin
			if (cur_phase == PH_START) begin
				first_err = ERR_EMPTY;
			end else begin
				width = 8 * (4 - dots_seen);
				if (cur_ovf || (width < 32 && (cur_value >> width) != '0)) begin
					first_err = ERR_RANGE;
				end
			end
		end
		r.address = '0;
		r.code    = first_err;
		if (first_err == ERR_NONE) begin
			r.address = {8'h00, octets_done};
			for (k = dots_seen; k < 4; k++) begin
				r.address[8*k +: 8] = cur_value[8*(3-k) +: 8];
			end
		end
		pending_addresses.push_back(r);
		clear_string();
	endfunction

	function automatic void note_mismatch(string what, logic [31:0] exp_val,
		logic [31:0] got_val);
		error_count++;
		if (error_count <= 10) begin
			$display("%s mismatch: expected %h, got %h", what, exp_val, got_val);
		end
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && chars_bus.valid === 1'b1 && chars_bus.ready === 1'b1) begin
			track_char(chars_bus.ch, chars_bus.last);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (results_bus.valid === 1'b1 && results_bus.ready === 1'b1) begin
				if (pending_addresses.size() == 0) begin
					note_mismatch("unexpected result", '0, results_bus.address);
				end else begin
					want = pending_addresses.pop_front();
					if (results_bus.address !== want.address) begin
						note_mismatch("address", want.address, results_bus.address);
					end
					if (results_bus.error_code !== want.code) begin
						note_mismatch("error_code", {29'b0, want.code},
							{29'b0, results_bus.error_code});
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					sink_quiet = !sink_quiet;
				end
				sink_hold = sink_quiet ? 0 : $urandom_range(0, 8);
			end
			if (sink_hold != 0) begin
				sink_hold--;
				results_bus.ready <= 1'b0;
			end else begin
				results_bus.ready <= 1'b1;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic fin, input bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			chars_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_bus.valid <= 1'b1;
		chars_bus.ch    <= c;
		chars_bus.last  <= fin;
		@(posedge clk);
		while (chars_bus.ready !== 1'b1) @(posedge clk);
		sent_chars++;
	endtask

	task automatic send_text(input char_seq_t s);
		bit quiet;
		int i;
		quiet = ($urandom_range(0, 3) == 0);
		for (i = 0; i < s.size(); i++) begin
			send_char(s[i], i == s.size() - 1, quiet);
		end
	endtask

	function automatic char_seq_t to_bytes(string s);
		char_seq_t q;
		int        i;
		for (i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		return q;
	endfunction

	function automatic string fmt_value(logic [32:0] v);
		string s;
		string prefix;
		int    zeros;
		int    i;
		zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
		case ($urandom_range(0, 2))
			0: begin
				s = $sformatf("%0d", v);
			end
			1: begin
				s = $sformatf("%0o", v);
				repeat (zeros + 1) s = {"0", s};
			end
			default: begin
				if (v == '0 && $urandom_range(0, 1) == 1) begin
					s = "";
				end else begin
					s = $sformatf("%0h", v);
				end
				for (i = 0; i < s.len(); i++) begin
					if (s[i] >= CH_LO_A && $urandom_range(0, 1) == 1) begin
						s[i] = s[i] - (CH_LO_A - CH_UP_A);
					end
				end
				repeat (zeros) s = {"0", s};
				if ($urandom_range(0, 1) == 1) begin
					prefix = "0x";
				end else begin
					prefix = "0X";
				end
				s = {prefix, s};
			end
		endcase
		return s;
	endfunction

	function automatic string overflow_digits();
		string s;
		int    n;
		s = $sformatf("%0d", $urandom_range(5, 9));
		n = $urandom_range(9, 11);
		repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	// width is the number of bits the part may fill
	function automatic string make_part(int width);
		logic [32:0] limit;
		logic [32:0] v;
		limit = (33'd1 << width) - 33'd1;
		case ($urandom_range(0, 11))
			0: v = '0;
			1: v = limit;
			2: v = limit + 33'd1;
			3: return overflow_digits();
			default: begin
				v = {1'b0, $urandom} >> $urandom_range(0, 31);
				if (v > limit) begin
					v = v & limit;
				end
			end
		endcase
		return fmt_value(v);
	endfunction

	function automatic string make_address();
		string s;
		int    nparts;
		int    p;
		s = "";
		nparts = $urandom_range(1, 4);
		for (p = 0; p < nparts; p++) begin
			if (p == nparts - 1) begin
				s = {s, make_part(8 * (5 - nparts))};
			end else begin
				s = {s, make_part(8), "."};
			end
		end
		return s;
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 5))
			0: return CH_DOT;
			1: return CH_ZERO + 8'($urandom_range(0, 9));
			2: return ($urandom_range(0, 1) == 1) ? CH_LO_X : CH_UP_X;
			3: return CH_LO_A + 8'($urandom_range(0, 6));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_directed();
		char_seq_t q;
		send_text(to_bytes("0xfF"));
		send_text(to_bytes("0X"));
		send_text(to_bytes("1."));
		send_text(to_bytes(".5"));
		send_text(to_bytes("09"));
		send_text(to_bytes("400."));
		send_text(to_bytes("1.2.3.4."));
		q = {8'hFF};
		send_text(q);
	endtask

	task automatic test_well_formed(input int count);
		int stop_at;
		stop_at = sent_chars + count;
		while (sent_chars < stop_at) begin
			send_text(to_bytes(make_address()));
		end
	endtask

	task automatic test_malformed(input int count);
		char_seq_t q;
		int        stop_at;
		stop_at = sent_chars + count;
		while (sent_chars < stop_at) begin
			q = to_bytes(make_address());
			case ($urandom_range(0, 6))
				0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
				1: q.insert($urandom_range(0, q.size()), 8'($urandom_range(0, 255)));
				2: q.push_back(CH_DOT);
				3: q.push_front(CH_DOT);
				4: q.insert($urandom_range(0, q.size()), CH_DOT);
				5: begin
					case ($urandom_range(0, 2))
						0: q.insert($urandom_range(0, q.size()), CH_SPACE);
						1: q.insert($urandom_range(0, q.size()), CH_TAB);
						default: q.insert($urandom_range(0, q.size()), CH_NUL);
					endcase
				end
				default: q = {q, to_bytes({".", make_part(8)})};
			endcase
			send_text(q);
		end
	endtask

	task automatic test_noise(input int count);
		char_seq_t q;
		int        stop_at;
		int        n;
		stop_at = sent_chars + count;
		while (sent_chars < stop_at) begin
			q = {};
			n = $urandom_range(1, 6);
			repeat (n) q.push_back(noise_byte());
			send_text(q);
		end
	endtask

	initial begin
		arst_n            = 1'b0;
		chars_bus.valid   = 1'b0;
		chars_bus.ch      = '0;
		chars_bus.last    = 1'b0;
		results_bus.ready = 1'b0;
		clear_string();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_well_formed(600);
		test_malformed(200);
		test_noise(100);
		chars_bus.valid <= 1'b0;

		@(posedge clk);
		while (pending_addresses.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
`default_nettype wire
